// ----- design/i2cm_pkg.sv -----
package i2cm_pkg;

   // sequencer phases, one-hot
   typedef enum logic [12:0] {
      PH_IDLE    = 13'b0_0000_0000_0001,
      PH_START_A = 13'b0_0000_0000_0010,
      PH_START_B = 13'b0_0000_0000_0100,
      PH_WR_A    = 13'b0_0000_0000_1000,
      PH_WR_B    = 13'b0_0000_0001_0000,
      PH_ACK_A   = 13'b0_0000_0010_0000,
      PH_ACK_B   = 13'b0_0000_0100_0000,
      PH_RD_A    = 13'b0_0000_1000_0000,
      PH_RD_B    = 13'b0_0001_0000_0000,
      PH_MACK_A  = 13'b0_0010_0000_0000,
      PH_MACK_B  = 13'b0_0100_0000_0000,
      PH_STOP_A  = 13'b0_1000_0000_0000,
      PH_STOP_B  = 13'b1_0000_0000_0000
   } phase_type;

   // which byte the write shifter is sending
   typedef enum logic [1:0] {
      ST_ADDR_W = 2'd0,
      ST_REG    = 2'd1,
      ST_DATA   = 2'd2,
      ST_ADDR_R = 2'd3
   } stage_type;

   localparam logic [2:0] OP_TICK     = 3'd0;
   localparam logic [2:0] OP_REG_WR   = 3'd1;
   localparam logic [2:0] OP_REG_RD   = 3'd2;
   localparam logic [2:0] OP_BURST_RD = 3'd3;
   localparam logic [2:0] OP_BYTE_WR  = 3'd4;
   localparam logic [2:0] OP_BYTE_RD  = 3'd5;

   localparam logic RW_WRITE = 1'b0;
   localparam logic RW_READ  = 1'b1;

   typedef struct packed {
      phase_type   phase;
      stage_type   stage;
      logic [3:0]  bit_pos;
      logic [7:0]  shift;
      logic [15:0] tick;
      logic [15:0] bytes_rem;
      logic [2:0]  cmd_op;
      logic [6:0]  cmd_addr;
      logic [7:0]  cmd_reg;
      logic [7:0]  cmd_data;
      logic        nack_seen;
      logic        scl;
      logic        sda;
   } state_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic [7:0] read_data;
      logic       read_valid;
      logic       read_last;
      logic       done_res;
      logic       nack;
   } result_type;

endpackage

// ----- design/i2cm_step.sv -----
module i2cm_step import i2cm_pkg::*; #(
   parameter int BURST_COUNT_MAX = 65535
) (
   input  state_type   cur,
   input  logic [15:0] half_period_ticks,
   input  logic [2:0]  operation,
   input  logic [6:0]  slave_address,
   input  logic [7:0]  register_address,
   input  logic [7:0]  write_data,
   input  logic [15:0] byte_count,
   input  logic        sda_in,
   output state_type   nxt,
   output result_type  res
);

   localparam logic [15:0] BurstMax = 16'(BURST_COUNT_MAX);

   // new phase: restart the half-period count and set the line drive
   function automatic state_type enter(state_type s, phase_type ph);
      state_type r;
      r = s;
      r.phase = ph;
      r.tick = '0;
      unique case (ph)
         PH_START_A: {r.scl, r.sda} = 2'b11;
         PH_START_B: {r.scl, r.sda} = 2'b10;
         PH_WR_A:    {r.scl, r.sda} = {1'b0, s.shift[7]};
         PH_WR_B:    {r.scl, r.sda} = {1'b1, s.shift[7]};
         PH_ACK_A:   {r.scl, r.sda} = 2'b01;
         PH_ACK_B:   {r.scl, r.sda} = 2'b11;
         PH_RD_A:    {r.scl, r.sda} = 2'b01;
         PH_RD_B:    {r.scl, r.sda} = 2'b11;
         PH_MACK_A:  {r.scl, r.sda} = {1'b0, s.bytes_rem == '0};
         PH_MACK_B:  {r.scl, r.sda} = {1'b1, s.bytes_rem == '0};
         PH_STOP_A:  {r.scl, r.sda} = 2'b00;
         PH_STOP_B:  {r.scl, r.sda} = 2'b10;
         default: begin
            r.phase = PH_IDLE;
            {r.scl, r.sda} = 2'b11;
         end
      endcase
      return r;
   endfunction

   logic [15:0] limit;
   logic [15:0] tick_inc;
   logic        half_done;

   assign limit     = (half_period_ticks == '0) ? 16'd1 : half_period_ticks;
   assign tick_inc  = cur.tick + 16'd1;
   assign half_done = tick_inc >= limit;

   always_comb begin
      state_type  s;
      result_type r;
      s = cur;
      r = '0;
      if (cur.phase == PH_IDLE) begin
         if (operation == OP_BURST_RD && byte_count == '0) begin
            r.done_res = 1'b1;
         end else if (operation >= OP_REG_WR && operation <= OP_BYTE_RD) begin
            s.cmd_op    = operation;
            s.cmd_addr  = slave_address;
            s.cmd_reg   = register_address;
            s.cmd_data  = write_data;
            s.nack_seen = 1'b0;
            if (operation == OP_BURST_RD) begin
               s.bytes_rem = (byte_count > BurstMax) ? BurstMax : byte_count;
            end else begin
               s.bytes_rem = 16'd1;
            end
            s.bit_pos = '0;
            if (operation == OP_BYTE_RD) begin
               s.stage = ST_ADDR_R;
               s.shift = {slave_address, RW_READ};
            end else begin
               s.stage = ST_ADDR_W;
               s.shift = {slave_address, RW_WRITE};
            end
            s = enter(s, PH_START_A);
         end
      end else begin
         s.tick = tick_inc;
         if (half_done) begin
            unique case (cur.phase)
               PH_START_A: s = enter(s, PH_START_B);
               PH_START_B: begin
                  s.bit_pos = '0;
                  s = enter(s, PH_WR_A);
               end
               PH_WR_A: s = enter(s, PH_WR_B);
               PH_WR_B: begin
                  s.shift   = {cur.shift[6:0], 1'b0};
                  s.bit_pos = cur.bit_pos + 4'd1;
                  s = enter(s, (s.bit_pos >= 4'd8) ? PH_ACK_A : PH_WR_A);
               end
               PH_ACK_A: s = enter(s, PH_ACK_B);
               PH_ACK_B: begin
                  if (sda_in) begin
                     s.nack_seen = 1'b1;
                     s = enter(s, PH_STOP_A);
                  end else begin
                     unique case (cur.stage)
                        ST_ADDR_W: begin
                           s.bit_pos = '0;
                           if (cur.cmd_op == OP_BYTE_WR) begin
                              s.stage = ST_DATA;
                              s.shift = cur.cmd_data;
                           end else begin
                              s.stage = ST_REG;
                              s.shift = cur.cmd_reg;
                           end
                           s = enter(s, PH_WR_A);
                        end
                        ST_REG: begin
                           s.bit_pos = '0;
                           if (cur.cmd_op == OP_REG_WR) begin
                              s.stage = ST_DATA;
                              s.shift = cur.cmd_data;
                              s = enter(s, PH_WR_A);
                           end else begin
                              // repeated start with the read address
                              s.stage = ST_ADDR_R;
                              s.shift = {cur.cmd_addr, RW_READ};
                              s = enter(s, PH_START_A);
                           end
                        end
                        ST_ADDR_R: begin
                           s.bit_pos = '0;
                           s.shift   = '0;
                           s = enter(s, PH_RD_A);
                        end
                        default: s = enter(s, PH_STOP_A);
                     endcase
                  end
               end
               PH_RD_A: s = enter(s, PH_RD_B);
               PH_RD_B: begin
                  s.shift   = {cur.shift[6:0], sda_in};
                  s.bit_pos = cur.bit_pos + 4'd1;
                  if (s.bit_pos >= 4'd8) begin
                     if (cur.bytes_rem != '0) begin
                        s.bytes_rem = cur.bytes_rem - 16'd1;
                     end
                     r.read_data  = s.shift;
                     r.read_valid = 1'b1;
                     r.read_last  = s.bytes_rem == '0;
                     s = enter(s, PH_MACK_A);
                  end else begin
                     s = enter(s, PH_RD_A);
                  end
               end
               PH_MACK_A: s = enter(s, PH_MACK_B);
               PH_MACK_B: begin
                  if (cur.bytes_rem == '0) begin
                     s = enter(s, PH_STOP_A);
                  end else begin
                     s.bit_pos = '0;
                     s.shift   = '0;
                     s = enter(s, PH_RD_A);
                  end
               end
               PH_STOP_A: s = enter(s, PH_STOP_B);
               PH_STOP_B: begin
                  r.done_res = 1'b1;
                  r.nack     = cur.nack_seen;
                  s = enter(s, PH_IDLE);
               end
               default: s = enter(s, PH_IDLE);
            endcase
         end
      end
      r.scl_level = s.scl;
      r.sda_level = s.sda;
      r.busy_res  = s.phase != PH_IDLE;
      nxt = s;
      res = r;
   end

endmodule

// ----- design/i2cm_rsp_fifo.sv -----
module i2cm_rsp_fifo import i2cm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       not_full,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign not_full  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !not_full))
      else $error("response buffer overflow");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("response buffer pointers out of step with count");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("response buffer count out of range");

endmodule

// ----- design/i2c_master_transaction_engine.sv -----
//  channel | ports  | moves
//  --------+--------+-------------------------------------------------------------
//  request | req_*  | one time-base tick: sampled SDA, plus a command taken when idle
//  result  | rsp_*  | SCL/SDA drive, busy, received byte, done and nack, per request
//  config  | csr_*  | half_period_ticks, written at once, no read-back
//
//  One request per clock: the sequencer steps once per accepted request and its
//  result is queued in a two-entry buffer, so requests flow while a result waits.
//  The request side stalls only when both buffer entries are occupied.
//  Synchronous reset: sequencer idle, both lines released, half period 5 ticks.
module i2c_master_transaction_engine import i2cm_pkg::*; #(
   parameter int BURST_COUNT_MAX = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [6:0]  req_slave_address,
   input  logic [7:0]  req_register_address,
   input  logic [7:0]  req_write_data,
   input  logic [15:0] req_byte_count,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_level,
   output logic        rsp_sda_level,
   output logic        rsp_busy_res,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_read_valid,
   output logic        rsp_read_last,
   output logic        rsp_done_res,
   output logic        rsp_nack,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_half_period_ticks
);

   localparam state_type StateReset = '{
      phase:     PH_IDLE,
      stage:     ST_ADDR_W,
      bit_pos:   '0,
      shift:     '0,
      tick:      '0,
      bytes_rem: '0,
      cmd_op:    OP_TICK,
      cmd_addr:  '0,
      cmd_reg:   '0,
      cmd_data:  '0,
      nack_seen: 1'b0,
      scl:       1'b1,
      sda:       1'b1
   };

   state_type   state_ff;
   state_type   state_in;
   result_type  step_res;
   result_type  rsp_data;
   logic [15:0] half_period_ff;
   logic        accept;

   assign accept = req_valid && req_ready;

   i2cm_step #(
      .BURST_COUNT_MAX(BURST_COUNT_MAX)
   ) u_step (
      .cur               (state_ff),
      .half_period_ticks (half_period_ff),
      .operation         (req_operation),
      .slave_address     (req_slave_address),
      .register_address  (req_register_address),
      .write_data        (req_write_data),
      .byte_count        (req_byte_count),
      .sda_in            (req_sda_in),
      .nxt               (state_in),
      .res               (step_res)
   );

   i2cm_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (step_res),
      .not_full  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= StateReset;
         half_period_ff <= 16'd5;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            half_period_ff <= csr_half_period_ticks;
         end
      end
   end

   assign rsp_scl_level  = rsp_data.scl_level;
   assign rsp_sda_level  = rsp_data.sda_level;
   assign rsp_busy_res   = rsp_data.busy_res;
   assign rsp_read_data  = rsp_data.read_data;
   assign rsp_read_valid = rsp_data.read_valid;
   assign rsp_read_last  = rsp_data.read_last;
   assign rsp_done_res   = rsp_data.done_res;
   assign rsp_nack       = rsp_data.nack;

   a_done_releases: assert property (@(posedge clock) disable iff (reset)
      (accept && step_res.done_res) |=>
         (state_ff.phase == PH_IDLE && state_ff.scl && state_ff.sda))
      else $error("done without returning to idle with lines released");

   a_stop_then_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.phase == PH_STOP_B && state_in.phase == PH_IDLE)
         |-> step_res.done_res)
      else $error("stop completed without done");

   a_read_only_in_rd: assert property (@(posedge clock) disable iff (reset)
      (accept && step_res.read_valid) |-> (state_ff.phase == PH_RD_B))
      else $error("read byte reported outside a read bit");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !accept |=> (state_ff == $past(state_ff)))
      else $error("sequencer moved without a request");

endmodule

// ----- tb/sv/tb.sv -----
import i2cm_pkg::*;

typedef struct {
   logic [2:0]  op;
   logic [6:0]  addr;
   logic [7:0]  reg_sel;
   logic [7:0]  data;
   logic [15:0] count;
   logic        sda;
} i2c_request_type;

class i2c_bus_scoreboard;
   result_type  expected_lines[$];
   logic [15:0] half_period;
   phase_type   phase;
   stage_type   stage;
   logic [3:0]  bit_pos;
   logic [7:0]  shift_reg;
   logic [15:0] tick_cnt;
   logic [15:0] bytes_left;
   logic [2:0]  cmd_op;
   logic [6:0]  cmd_addr;
   logic [7:0]  cmd_reg;
   logic [7:0]  cmd_data;
   logic        nack_seen;
   logic        scl_drv;
   logic        sda_drv;
   int          errors;
   int          checked;
   int          noted;
   int          started[8];
   int          empty_bursts;
   int          bytes_read;
   int          nacks_reported;

   function new();
      half_period = 16'd5;
      phase       = PH_IDLE;
      stage       = ST_ADDR_W;
      bit_pos     = '0;
      shift_reg   = '0;
      tick_cnt    = '0;
      bytes_left  = '0;
      cmd_op      = OP_TICK;
      cmd_addr    = '0;
      cmd_reg     = '0;
      cmd_data    = '0;
      nack_seen   = 1'b0;
      scl_drv     = 1'b1;
      sda_drv     = 1'b1;
   endfunction

   function int limit();
      return (half_period == 16'd0) ? 1 : int'(half_period);
   endfunction

   function bit busy();
      return phase != PH_IDLE;
   endfunction

   // last tick of the ACK high half: the only tick whose SDA level counts
   function bit at_ack_sample();
      return phase == PH_ACK_B && int'(tick_cnt) + 1 >= limit();
   endfunction

   function void enter(phase_type ph);
      logic b;
      b        = shift_reg[7];
      phase    = ph;
      tick_cnt = '0;
      case (ph)
         PH_START_A: {scl_drv, sda_drv} = 2'b11;
         PH_START_B: {scl_drv, sda_drv} = 2'b10;
         PH_WR_A:    {scl_drv, sda_drv} = {1'b0, b};
         PH_WR_B:    {scl_drv, sda_drv} = {1'b1, b};
         PH_ACK_A:   {scl_drv, sda_drv} = 2'b01;
         PH_ACK_B:   {scl_drv, sda_drv} = 2'b11;
         PH_RD_A:    {scl_drv, sda_drv} = 2'b01;
         PH_RD_B:    {scl_drv, sda_drv} = 2'b11;
         PH_MACK_A:  {scl_drv, sda_drv} = {1'b0, bytes_left == 16'd0};
         PH_MACK_B:  {scl_drv, sda_drv} = {1'b1, bytes_left == 16'd0};
         PH_STOP_A:  {scl_drv, sda_drv} = 2'b00;
         PH_STOP_B:  {scl_drv, sda_drv} = 2'b10;
         default: begin
            phase              = PH_IDLE;
            {scl_drv, sda_drv} = 2'b11;
         end
      endcase
   endfunction

   function void write_next(stage_type st, logic [7:0] b);
      stage     = st;
      shift_reg = b;
      bit_pos   = '0;
   endfunction

   function void note_request(i2c_request_type r);
      result_type res;
      res = '0;
      if (phase == PH_IDLE) begin
         if (r.op == OP_BURST_RD && r.count == 16'd0) begin
            res.done_res = 1'b1;
            empty_bursts++;
         end else if (r.op >= OP_REG_WR && r.op <= OP_BYTE_RD) begin
            cmd_op     = r.op;
            cmd_addr   = r.addr;
            cmd_reg    = r.reg_sel;
            cmd_data   = r.data;
            nack_seen  = 1'b0;
            bytes_left = (r.op == OP_BURST_RD) ? r.count : 16'd1;
            if (r.op == OP_BYTE_RD) write_next(ST_ADDR_R, {r.addr, RW_READ});
            else write_next(ST_ADDR_W, {r.addr, RW_WRITE});
            enter(PH_START_A);
            started[r.op]++;
         end
      end else begin
         tick_cnt++;
         if (int'(tick_cnt) >= limit()) begin
            case (phase)
               PH_START_A: enter(PH_START_B);
               PH_START_B: begin
                  bit_pos = '0;
                  enter(PH_WR_A);
               end
               PH_WR_A: enter(PH_WR_B);
               PH_WR_B: begin
                  shift_reg = {shift_reg[6:0], 1'b0};
                  bit_pos++;
                  enter(bit_pos >= 4'd8 ? PH_ACK_A : PH_WR_A);
               end
               PH_ACK_A: enter(PH_ACK_B);
               PH_ACK_B: begin
                  if (r.sda) begin
                     nack_seen = 1'b1;
                     enter(PH_STOP_A);
                  end else begin
                     case (stage)
                        ST_ADDR_W: begin
                           if (cmd_op == OP_BYTE_WR) write_next(ST_DATA, cmd_data);
                           else write_next(ST_REG, cmd_reg);
                           enter(PH_WR_A);
                        end
                        ST_REG: begin
                           if (cmd_op == OP_REG_WR) begin
                              write_next(ST_DATA, cmd_data);
                              enter(PH_WR_A);
                           end else begin
                              // register or burst read: repeated start with the read address
                              write_next(ST_ADDR_R, {cmd_addr, RW_READ});
                              enter(PH_START_A);
                           end
                        end
                        ST_ADDR_R: begin
                           bit_pos   = '0;
                           shift_reg = '0;
                           enter(PH_RD_A);
                        end
                        default: enter(PH_STOP_A);
                     endcase
                  end
               end
               PH_RD_A: enter(PH_RD_B);
               PH_RD_B: begin
                  shift_reg = {shift_reg[6:0], r.sda};
                  bit_pos++;
                  if (bit_pos >= 4'd8) begin
                     if (bytes_left != 16'd0) bytes_left--;
                     res.read_data  = shift_reg;
                     res.read_valid = 1'b1;
                     res.read_last  = bytes_left == 16'd0;
                     bytes_read++;
                     enter(PH_MACK_A);
                  end else begin
                     enter(PH_RD_A);
                  end
               end
               PH_MACK_A: enter(PH_MACK_B);
               PH_MACK_B: begin
                  if (bytes_left == 16'd0) begin
                     enter(PH_STOP_A);
                  end else begin
                     bit_pos   = '0;
                     shift_reg = '0;
                     enter(PH_RD_A);
                  end
               end
               PH_STOP_A: enter(PH_STOP_B);
               default: begin
                  res.done_res = 1'b1;
                  res.nack     = nack_seen;
                  if (nack_seen) nacks_reported++;
                  enter(PH_IDLE);
               end
            endcase
         end
      end
      res.scl_level = scl_drv;
      res.sda_level = sda_drv;
      res.busy_res  = phase != PH_IDLE;
      expected_lines.push_back(res);
      noted++;
   endfunction

   task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   task compare_field(string name, logic [7:0] got_v, logic [7:0] want_v);
      if (got_v !== want_v)
         report_mismatch($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                                   checked, name, got_v, want_v));
   endtask

   task check_result(result_type got);
      result_type want;
      checked++;
      if (expected_lines.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with no request pending", checked));
         return;
      end
      want = expected_lines.pop_front();
      compare_field("scl_level",  got.scl_level,  want.scl_level);
      compare_field("sda_level",  got.sda_level,  want.sda_level);
      compare_field("busy_res",   got.busy_res,   want.busy_res);
      compare_field("read_data",  got.read_data,  want.read_data);
      compare_field("read_valid", got.read_valid, want.read_valid);
      compare_field("read_last",  got.read_last,  want.read_last);
      compare_field("done_res",   got.done_res,   want.done_res);
      compare_field("nack",       got.nack,       want.nack);
   endtask
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock                 = 1'b0;
   logic        reset                 = 1'b1;
   logic        req_valid             = 1'b0;
   logic        req_ready;
   logic [2:0]  req_operation         = OP_TICK;
   logic [6:0]  req_slave_address     = '0;
   logic [7:0]  req_register_address  = '0;
   logic [7:0]  req_write_data        = '0;
   logic [15:0] req_byte_count        = '0;
   logic        req_sda_in            = 1'b1;
   logic        rsp_valid;
   logic        rsp_ready             = 1'b0;
   logic        rsp_scl_level;
   logic        rsp_sda_level;
   logic        rsp_busy_res;
   logic [7:0]  rsp_read_data;
   logic        rsp_read_valid;
   logic        rsp_read_last;
   logic        rsp_done_res;
   logic        rsp_nack;
   logic        csr_wr_en             = 1'b0;
   logic [15:0] csr_half_period_ticks = '0;

   i2c_bus_scoreboard sb = new();
   bit no_idle = 1'b0;
   int tx_calm = 0;

   i2c_master_transaction_engine dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_slave_address     (req_slave_address),
      .req_register_address  (req_register_address),
      .req_write_data        (req_write_data),
      .req_byte_count        (req_byte_count),
      .req_sda_in            (req_sda_in),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_scl_level         (rsp_scl_level),
      .rsp_sda_level         (rsp_sda_level),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_read_data         (rsp_read_data),
      .rsp_read_valid        (rsp_read_valid),
      .rsp_read_last         (rsp_read_last),
      .rsp_done_res          (rsp_done_res),
      .rsp_nack              (rsp_nack),
      .csr_wr_en             (csr_wr_en),
      .csr_half_period_ticks (csr_half_period_ticks)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(result_type'({rsp_scl_level, rsp_sda_level, rsp_busy_res,
                                       rsp_read_data, rsp_read_valid, rsp_read_last,
                                       rsp_done_res, rsp_nack}));
   end

   // result side: random stalls, calm stretches, and one long hold-off
   initial begin
      int hold_left;
      int gap_left;
      int calm_left;
      bit hold_done;
      hold_left = 0;
      gap_left  = 0;
      calm_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && sb.checked >= 150) begin
            hold_done = 1'b1;
            hold_left = 400;
            rsp_ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_ready <= 1'b0;
            if (gap_left == 0 && $urandom_range(0, 3) == 0) calm_left = $urandom_range(50, 400);
         end else if (calm_left > 0 || no_idle) begin
            if (calm_left > 0) calm_left--;
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 11) == 0) begin
            gap_left = $urandom_range(1, 10) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_request(i2c_request_type r);
      int gap;
      if (!no_idle && tx_calm == 0 && $urandom_range(0, 11) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         if ($urandom_range(0, 3) == 0) tx_calm = $urandom_range(50, 400);
      end else if (tx_calm > 0) begin
         tx_calm--;
      end
      req_valid            <= 1'b1;
      req_operation        <= r.op;
      req_slave_address    <= r.addr;
      req_register_address <= r.reg_sel;
      req_write_data       <= r.data;
      req_byte_count       <= r.count;
      req_sda_in           <= r.sda;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   function automatic i2c_request_type random_request();
      i2c_request_type r;
      r.op      = 3'($urandom_range(0, 7));
      r.addr    = 7'($urandom_range(0, 127));
      r.reg_sel = 8'($urandom_range(0, 255));
      r.data    = 8'($urandom_range(0, 255));
      r.count   = 16'($urandom_range(0, 65535));
      r.sda     = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // one command request, then ticks until the bus is idle again; the target
   // acks every byte except the one numbered nack_ack (counted from 0)
   task automatic run_transaction(logic [2:0] op, logic [6:0] addr, logic [7:0] reg_sel,
                                  logic [7:0] data, logic [15:0] count, int nack_ack);
      i2c_request_type r;
      int acks;
      acks = 0;
      r = '{op, addr, reg_sel, data, count, 1'($urandom_range(0, 1))};
      send_request(r);
      while (sb.busy()) begin
         r = random_request();
         // mostly plain ticks; the odd command while busy must be ignored
         if ($urandom_range(0, 9) != 0) r.op = OP_TICK;
         if (sb.at_ack_sample()) begin
            r.sda = (acks == nack_ack);
            acks++;
         end
         send_request(r);
      end
   endtask

   task automatic random_transaction();
      logic [2:0]  op;
      logic [15:0] count;
      int          pick;
      int          nack_ack;
      pick = $urandom_range(0, 99);
      if (pick < 20) op = OP_REG_WR;
      else if (pick < 40) op = OP_REG_RD;
      else if (pick < 65) op = OP_BURST_RD;
      else if (pick < 80) op = OP_BYTE_WR;
      else if (pick < 95) op = OP_BYTE_RD;
      else op = 3'($urandom_range(6, 7));
      if ($urandom_range(0, 5) == 0) count = '0;
      else if ($urandom_range(0, 15) == 0) count = 16'($urandom_range(4, 6));
      else count = 16'($urandom_range(1, 3));
      nack_ack = ($urandom_range(0, 11) == 0) ? int'($urandom_range(0, 3)) : -1;
      run_transaction(op, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), count, nack_ack);
      repeat ($urandom_range(0, 3))
         run_transaction(OP_TICK, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), -1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_lines.size() != 0) @(posedge clock);
   endtask

   task automatic write_half_period(logic [15:0] v);
      settle();
      csr_wr_en             <= 1'b1;
      csr_half_period_ticks <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.half_period = v;
   endtask

   // random transactions until the request count reaches target
   task automatic run_phase(logic [15:0] half, int target);
      write_half_period(half);
      do random_transaction(); while (sb.noted < target);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset half period: empty burst, bare tick, read with its address refused
      run_transaction(OP_BURST_RD, 7'h2A, 8'h55, 8'h00, 16'd0, -1);
      run_transaction(OP_TICK,     7'h7F, 8'hFF, 8'hFF, 16'hFFFF, -1);
      run_transaction(OP_BYTE_RD,  7'h40, 8'h00, 8'h00, 16'd0, 0);

      // directed, one tick per half
      write_half_period(16'd1);
      run_transaction(OP_REG_WR,   7'h7F, 8'hFF, 8'hFF, 16'hFFFF, -1);
      run_transaction(OP_REG_RD,   7'h55, 8'hAA, 8'h00, 16'd0, -1);
      run_transaction(OP_BURST_RD, 7'h01, 8'h01, 8'h00, 16'd2, -1);
      run_transaction(OP_BYTE_WR,  7'h7F, 8'h00, 8'h80, 16'd0, -1);
      run_transaction(OP_BYTE_RD,  7'h01, 8'h00, 8'h00, 16'd0, -1);
      run_transaction(3'd6,        7'h12, 8'h34, 8'h56, 16'd7, -1);
      run_transaction(3'd7,        7'h7F, 8'hFF, 8'hFF, 16'hFFFF, -1);
      // missing ACK on the register index, on the read address
      run_transaction(OP_REG_WR,   7'h33, 8'h44, 8'h55, 16'd0, 1);
      run_transaction(OP_REG_RD,   7'h66, 8'h77, 8'h00, 16'd0, 2);

      // zero acts as one tick per half
      run_phase(16'd0, 540);

      // largest half period: only requests that finish at once
      write_half_period(16'hFFFF);
      repeat (2)
         run_transaction(OP_BURST_RD, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 16'd0, -1);
      run_transaction(3'd6, 7'h00, 8'h00, 8'h00, 16'hFFFF, -1);

      no_idle = 1'b1;
      run_phase(16'd1, 600);

      settle();
      repeat (20) @(posedge clock);
      if (sb.expected_lines.size() != 0)
         sb.report_mismatch($sformatf("%0d expected results never arrived",
                                      sb.expected_lines.size()));

      $display("%0d requests, %0d results checked; started %0d reg wr, %0d reg rd,",
               sb.noted, sb.checked, sb.started[OP_REG_WR], sb.started[OP_REG_RD]);
      $display("%0d burst rd (+%0d empty), %0d byte wr, %0d byte rd, %0d bytes, %0d NACKs",
               sb.started[OP_BURST_RD], sb.empty_bursts, sb.started[OP_BYTE_WR],
               sb.started[OP_BYTE_RD], sb.bytes_read, sb.nacks_reported);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
